FILE: rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg - circle scene signed distance shared definitions
// request and result payloads, configuration indexes, sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

	localparam int DEF_MAX_CIRCLES   = 64;
	localparam int DEF_MAX_GRID_SIDE = 1024;

	localparam int CW  = 24; // coordinate width, signed q16.8
	localparam int RW  = 23; // radius and cell size width
	localparam int PW  = 38; // doubled cell center and distance width
	localparam int MW  = 30; // shared multiplier operand width
	localparam int RTW = 30; // square root result width

	localparam int CFG_AW = 4;

	localparam logic [CFG_AW-1:0] REG_MIN_X       = 4'd0;
	localparam logic [CFG_AW-1:0] REG_MIN_Y       = 4'd1;
	localparam logic [CFG_AW-1:0] REG_MAX_X       = 4'd2;
	localparam logic [CFG_AW-1:0] REG_MAX_Y       = 4'd3;
	localparam logic [CFG_AW-1:0] REG_CELL_SIZE   = 4'd4;
	localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 4'd5;
	localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 4'd6;
	localparam logic [CFG_AW-1:0] REG_OBST_COUNT  = 4'd7;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [6:0] OCC_FULL = 7'd100;

	typedef struct packed {
		logic                  mode;
		logic [5:0]            slot;
		logic signed [CW-1:0]  center_x;
		logic signed [CW-1:0]  center_y;
		logic [RW-1:0]         radius;
		logic signed [11:0]    cell_x;
		logic signed [11:0]    cell_y;
	} in_t;

	typedef struct packed {
		logic                  in_grid;
		logic signed [CW-1:0]  distance;
		logic [6:0]            occupancy;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_PXY,
		ST_BND,
		ST_RD,
		ST_FETCH,
		ST_SQX,
		ST_SQY,
		ST_SQS,
		ST_SQRT,
		ST_MIN,
		ST_OCC,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/csd_isqrt.sv
// ----------------------------------------------------------------------------
// csd_isqrt - iterative integer square root
// one result bit per cycle, floor of the square root of the radicand
// ----------------------------------------------------------------------------
`default_nettype none

module csd_isqrt #(
	parameter int RTW = csd_pkg::RTW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2*RTW-1:0]  radicand,
	output logic                   done,
	output logic [RTW-1:0]         root
);

	localparam int RMW = RTW + 4;
	localparam int CNW = (RTW > 1) ? $clog2(RTW) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNW-1:0]   cnt_q;
	logic [2*RTW-1:0] rad_q;
	logic [RMW-1:0]   rem_q;
	logic [RTW-1:0]   root_q;

	logic [RMW-1:0]   rem_sh;
	logic [RMW-1:0]   trial;
	logic             fits;

	assign rem_sh = {rem_q[RMW-3:0], rad_q[2*RTW-1 -: 2]};
	assign trial  = RMW'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(RTW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RTW-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RTW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: rtl/circle_scene_signed_distance_unit.sv
// ----------------------------------------------------------------------------
// circle_scene_signed_distance_unit - on demand signed distance for a grid cell
// circle table, shared multiplier, bit serial square root and divider
// ----------------------------------------------------------------------------
// usage
//   req channel: valid/ready request, mode 0 loads a circle into table entry
//   slot, mode 1 queries the cell (cell_x, cell_y)
//   rsp channel: valid/ready, one result per request (in_grid, distance,
//   occupancy); a load answers with all zeros, a cell outside the grid with
//   occupancy 100
//   cfg channel: write only, always ready, cfg_addr picks the register
//   a load or an outside cell goes straight from the request to the final step,
//   which loads the result register; the block then takes the next request
//   a query works out the cell center and the bounds and then, for each of the
//   n circles in use, does the table read, two squarings on the shared multiplier,
//   the one bit per cycle square root unit and the compare; a far circle skips
//   the squarings and the root, and a distance outside the occupancy ramp skips
//   the divide
//   one request is worked on at a time; req_ready is low until it is done
//   a result waiting in the output register holds the sequencer at its last
//   step, so a stalled receiver stops the block after one further request
//   reset restores the default scene and clears the sequencer; the circle
//   table is not cleared and must be loaded before it is queried
// ----------------------------------------------------------------------------
`default_nettype none

module circle_scene_signed_distance_unit #(
	parameter int MAX_CIRCLES   = csd_pkg::DEF_MAX_CIRCLES,
	parameter int MAX_GRID_SIDE = csd_pkg::DEF_MAX_GRID_SIDE
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire csd_pkg::in_t                req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output csd_pkg::out_t                    rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [csd_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [csd_pkg::CW-1:0]      cfg_wdata
);

	localparam int CW  = csd_pkg::CW;
	localparam int RW  = csd_pkg::RW;
	localparam int PW  = csd_pkg::PW;
	localparam int MW  = csd_pkg::MW;
	localparam int RTW = csd_pkg::RTW;
	localparam int AW  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int KW  = $clog2(MAX_CIRCLES + 1);
	localparam int EW  = 2 * CW + RW; // table entry: x, y, radius

	// configuration registers
	logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [RW-1:0]        cell_size_q;
	logic [10:0]          grid_w_q, grid_h_q;
	logic [6:0]           obst_cnt_q;

	// sequencer and datapath registers
	csd_pkg::state_t      state_q, state_d;
	csd_pkg::in_t         req_q;
	logic [2*MW-1:0]      prod_q;
	logic [2*MW-1:0]      sqx_q;
	logic signed [PW-1:0] px2_q, py2_q, d_q;
	logic [1:0]           bstep_q;
	logic [KW-1:0]        k_q, n_q;
	logic [EW-1:0]        ent_q;
	logic [MW-1:0]        adx_q, ady_q;
	logic [RW-1:0]        rad_q;
	logic                 far_q;
	logic [31:0]          rem_q;
	logic [2:0]           dstep_q;
	logic [6:0]           occ_q;
	logic                 ing_q;
	logic                 rsp_valid_q;
	csd_pkg::out_t        rsp_q;

	// circle table
	logic [EW-1:0]        mem [MAX_CIRCLES];

	// combinational
	logic                 req_fire;
	logic                 rsp_load;
	logic [RW-1:0]        cell_eff;
	logic [10:0]          gw, gh;
	logic                 cell_in;
	logic [KW-1:0]        n_d;
	logic [MW-1:0]        mul_a, mul_b;
	logic [2*MW-1:0]      mul_p;
	logic signed [PW-1:0] mnx2, mny2, mxx2, mxy2;
	logic signed [PW-1:0] prod_s, bterm, bhalf;
	logic signed [PW-1:0] dx, dy, adx, ady;
	logic                 far;
	logic                 last_k;
	logic [2*MW:0]        sq_sum;
	logic                 sq_start, sq_done;
	logic [RTW-1:0]       root;
	logic signed [PW-1:0] tdist;
	logic [26:0]          ten_cell;
	logic [31:0]          num0;
	logic [31:0]          trial_div;
	logic [AW+5:0]        slot_ext;
	logic                 slot_ok;
	logic [23:0]          den;
	logic signed [CW-1:0] dist_sat;

	assign cfg_ready = 1'b1;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q     <= '0;
			min_y_q     <= '0;
			max_x_q     <= CW'(2560);
			max_y_q     <= CW'(2560);
			cell_size_q <= RW'(256);
			grid_w_q    <= 11'd10;
			grid_h_q    <= 11'd10;
			obst_cnt_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				csd_pkg::REG_MIN_X:       min_x_q     <= cfg_wdata;
				csd_pkg::REG_MIN_Y:       min_y_q     <= cfg_wdata;
				csd_pkg::REG_MAX_X:       max_x_q     <= cfg_wdata;
				csd_pkg::REG_MAX_Y:       max_y_q     <= cfg_wdata;
				csd_pkg::REG_CELL_SIZE:   cell_size_q <= cfg_wdata[RW-1:0];
				csd_pkg::REG_GRID_WIDTH:  grid_w_q    <= cfg_wdata[10:0];
				csd_pkg::REG_GRID_HEIGHT: grid_h_q    <= cfg_wdata[10:0];
				csd_pkg::REG_OBST_COUNT:  obst_cnt_q  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// scene constants derived from the registers
	assign cell_eff = (cell_size_q == '0) ? RW'(1) : cell_size_q;
	assign gw = (32'(grid_w_q) > MAX_GRID_SIDE) ? 11'(MAX_GRID_SIDE) : grid_w_q;
	assign gh = (32'(grid_h_q) > MAX_GRID_SIDE) ? 11'(MAX_GRID_SIDE) : grid_h_q;
	assign n_d = (32'(obst_cnt_q) > MAX_CIRCLES) ? KW'(MAX_CIRCLES) : KW'(obst_cnt_q);
	assign cell_in = !req.cell_x[11] && !req.cell_y[11]
		&& (req.cell_x[10:0] < gw) && (req.cell_y[10:0] < gh);

	assign slot_ext = {AW'(0), req.slot};
	assign slot_ok  = (32'(req.slot) < MAX_CIRCLES);

	assign req_fire = req_valid && req_ready;

	// doubled bounds, everything below runs with 9 fraction bits
	assign mnx2 = PW'(min_x_q) <<< 1;
	assign mny2 = PW'(min_y_q) <<< 1;
	assign mxx2 = PW'(max_x_q) <<< 1;
	assign mxy2 = PW'(max_y_q) <<< 1;
	assign prod_s = $signed({1'b0, prod_q[PW-2:0]});

	// one bound term per cycle
	always_comb begin
		case (bstep_q)
			2'd0:    bterm = px2_q - mnx2;
			2'd1:    bterm = mxx2 - px2_q;
			2'd2:    bterm = py2_q - mny2;
			default: bterm = mxy2 - py2_q;
		endcase
	end
	assign bhalf = bterm >>> 1;

	// circle offset from the registered table entry
	assign dx  = px2_q - (PW'($signed(ent_q[EW-1 -: CW])) <<< 1);
	assign dy  = py2_q - (PW'($signed(ent_q[RW +: CW])) <<< 1);
	assign adx = dx[PW-1] ? -dx : dx;
	assign ady = dy[PW-1] ? -dy : dy;
	// a center this far away cannot set the result
	assign far = (|adx[PW-1:MW]) || (|ady[PW-1:MW]);
	assign last_k = (k_q + 1'b1) == n_q;

	// shared multiplier
	assign mul_p = mul_a * mul_b;

	assign sq_sum = {1'b0, sqx_q} + {1'b0, prod_q};

	assign tdist = $signed({{(PW-RTW){1'b0}}, root}) - $signed({{(PW-RW){1'b0}}, rad_q});

	// occupancy quotient: (201 cell - 20 d) / (2 cell)
	assign ten_cell  = ({4'b0, cell_eff} << 3) + ({4'b0, cell_eff} << 1);
	assign num0      = ({9'b0, cell_eff} << 7) + ({9'b0, cell_eff} << 6)
		+ ({9'b0, cell_eff} << 3) + {9'b0, cell_eff}
		- ({5'b0, d_q[26:0]} << 4) - ({5'b0, d_q[26:0]} << 2);
	assign den       = {cell_eff, 1'b0};
	assign trial_div = {8'b0, den} << dstep_q;

	csd_isqrt #(
		.RTW(RTW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({1'b0, sq_sum[2*MW:2]}),
		.done     (sq_done),
		.root     (root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csd_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (req.mode == csd_pkg::MODE_QUERY && cell_in)
						state_d = csd_pkg::ST_MULX;
					else
						state_d = csd_pkg::ST_FIN;
				end
			end
			csd_pkg::ST_MULX: state_d = csd_pkg::ST_MULY;
			csd_pkg::ST_MULY: state_d = csd_pkg::ST_PXY;
			csd_pkg::ST_PXY:  state_d = csd_pkg::ST_BND;
			csd_pkg::ST_BND: begin
				if (bstep_q == 2'd3)
					state_d = (n_q == '0) ? csd_pkg::ST_OCC : csd_pkg::ST_RD;
			end
			csd_pkg::ST_RD:    state_d = csd_pkg::ST_FETCH;
			csd_pkg::ST_FETCH: state_d = csd_pkg::ST_SQX;
			csd_pkg::ST_SQX: begin
				if (far_q)
					state_d = last_k ? csd_pkg::ST_OCC : csd_pkg::ST_RD;
				else
					state_d = csd_pkg::ST_SQY;
			end
			csd_pkg::ST_SQY: state_d = csd_pkg::ST_SQS;
			csd_pkg::ST_SQS: state_d = csd_pkg::ST_SQRT;
			csd_pkg::ST_SQRT: begin
				if (sq_done)
					state_d = csd_pkg::ST_MIN;
			end
			csd_pkg::ST_MIN: state_d = last_k ? csd_pkg::ST_OCC : csd_pkg::ST_RD;
			csd_pkg::ST_OCC: begin
				if (d_q[PW-1] || d_q >= $signed({11'b0, ten_cell}))
					state_d = csd_pkg::ST_FIN;
				else
					state_d = csd_pkg::ST_DIV;
			end
			csd_pkg::ST_DIV: begin
				if (dstep_q == 3'd0)
					state_d = csd_pkg::ST_FIN;
			end
			csd_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready)
					state_d = csd_pkg::ST_IDLE;
			end
			default: state_d = csd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		sq_start  = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			csd_pkg::ST_IDLE: req_ready = 1'b1;
			csd_pkg::ST_MULX: begin
				mul_a = MW'({req_q.cell_x[10:0], 1'b1});
				mul_b = MW'(cell_eff);
			end
			csd_pkg::ST_MULY: begin
				mul_a = MW'({req_q.cell_y[10:0], 1'b1});
				mul_b = MW'(cell_eff);
			end
			csd_pkg::ST_SQX: begin
				mul_a = adx_q;
				mul_b = adx_q;
			end
			csd_pkg::ST_SQY: begin
				mul_a = ady_q;
				mul_b = ady_q;
			end
			csd_pkg::ST_SQS: sq_start = 1'b1;
			csd_pkg::ST_FIN: rsp_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csd_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// table write on a load request, registered read per circle
	always_ff @(posedge clk) begin
		if (req_fire && req.mode == csd_pkg::MODE_LOAD && slot_ok)
			mem[slot_ext[AW-1:0]] <= {req.center_x, req.center_y, req.radius};
		if (state_q == csd_pkg::ST_RD)
			ent_q <= mem[k_q[AW-1:0]];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			csd_pkg::ST_IDLE: begin
				req_q   <= req;
				n_q     <= n_d;
				k_q     <= '0;
				bstep_q <= '0;
				d_q     <= '0;
				ing_q   <= 1'b0;
				occ_q   <= (req.mode == csd_pkg::MODE_LOAD) ? 7'd0 : csd_pkg::OCC_FULL;
			end
			csd_pkg::ST_MULX: prod_q <= mul_p;
			csd_pkg::ST_MULY: begin
				prod_q <= mul_p;
				px2_q  <= mnx2 + prod_s;
			end
			csd_pkg::ST_PXY: py2_q <= mny2 + prod_s;
			csd_pkg::ST_BND: begin
				bstep_q <= bstep_q + 1'b1;
				if (bstep_q == 2'd0 || bhalf < d_q)
					d_q <= bhalf;
			end
			csd_pkg::ST_FETCH: begin
				adx_q <= adx[MW-1:0];
				ady_q <= ady[MW-1:0];
				rad_q <= ent_q[RW-1:0];
				far_q <= far;
			end
			csd_pkg::ST_SQX: begin
				prod_q <= mul_p;
				if (far_q)
					k_q <= k_q + 1'b1;
			end
			csd_pkg::ST_SQY: begin
				sqx_q  <= prod_q;
				prod_q <= mul_p;
			end
			csd_pkg::ST_MIN: begin
				k_q <= k_q + 1'b1;
				if (tdist < d_q)
					d_q <= tdist;
			end
			csd_pkg::ST_OCC: begin
				ing_q   <= 1'b1;
				rem_q   <= num0;
				dstep_q <= 3'd6;
				occ_q   <= d_q[PW-1] ? csd_pkg::OCC_FULL : 7'd0;
			end
			csd_pkg::ST_DIV: begin
				dstep_q <= dstep_q - 1'b1;
				if (rem_q >= trial_div) begin
					rem_q          <= rem_q - trial_div;
					occ_q[dstep_q] <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// distance saturation to the port width
	always_comb begin
		if (d_q > $signed(PW'(8388607)))
			dist_sat = CW'(8388607);
		else if (d_q < -$signed(PW'(8388608)))
			dist_sat = -CW'(8388608);
		else
			dist_sat = d_q[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.in_grid   <= ing_q;
			rsp_q.distance  <= ing_q ? dist_sat : '0;
			rsp_q.occupancy <= occ_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// req_ready is low in the cycle after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// the root unit answers only while the sequencer waits for it
	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == csd_pkg::ST_SQRT)
		else $error("square root done out of sequence");

	// circle index never passes the count in use
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != csd_pkg::ST_IDLE |-> k_q <= n_q)
		else $error("circle index out of range");

	// occupancy stays within its scale
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.occupancy <= csd_pkg::OCC_FULL)
		else $error("occupancy above full scale");

	// results only appear after the final sequencer step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == csd_pkg::ST_FIN)
		else $error("result without final step");
`endif

endmodule

`default_nettype wire
